/* rtl/bounded_set_span_tracker_defines.svh */
// ----------------------------------------------------------------------------
// Bounded set span tracker assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_SET_SPAN_TRACKER_DEFINES_SVH
`define BOUNDED_SET_SPAN_TRACKER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BSST_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BSST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/bsst_pkg.sv */
// ----------------------------------------------------------------------------
// Bounded set span tracker package
// Sizes, register map, result codes and controller states.
// ----------------------------------------------------------------------------
`default_nettype none

package bsst_pkg;

  localparam int MAX_ENTRIES = 1024;
  localparam int ADDR_W      = $clog2(MAX_ENTRIES);
  localparam int COUNT_W     = $clog2(MAX_ENTRIES + 1);

  localparam int VALUE_W     = 32;
  localparam int CAP_W       = 11;
  localparam int OUT_COUNT_W = 11;
  localparam int STATUS_W    = 2;

  localparam int S_TDATA_W   = 32;
  localparam int M_TDATA_W   = 80;
  localparam int M_TUSER_W   = 3;

  localparam int APB_ADDR_W  = 3;
  localparam int APB_DATA_W  = 32;

  localparam logic [CAP_W-1:0]   CAP_RESET = CAP_W'(1024);
  localparam logic [VALUE_W-1:0] SIGN_BIT  = 32'h8000_0000;

  // Register word index, taken from paddr[2].
  localparam logic REG_CAPACITY = 1'b0;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_NEW  = 2'd0,
    STATUS_DUP  = 2'd1,
    STATUS_FULL = 2'd2
  } bsst_status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } bsst_state_t;

endpackage

`default_nettype wire

/* rtl/bounded_set_span_tracker.sv */
// ----------------------------------------------------------------------------
// Bounded set span tracker
// Inserts signed values into a bounded set of distinct integers and reports
// the smallest neighbor gap and the full range after every transaction.
// ----------------------------------------------------------------------------
// Each input transaction carries one signed 32-bit value and produces exactly
// one result transaction. The stored entries live in a single-port memory of
// MAX_ENTRIES words; every insert reads all held entries through that port,
// one per cycle, to detect a duplicate and find the nearest lower and upper
// neighbors. When the set has no room, an item goes from acceptance to
// result through the finish step alone, since the set is full and the
// value is rejected without a scan. A new input is taken as soon as the
// controller is back in idle, even while the previous result still waits on
// the output register. The capacity register (byte address 0) limits the set
// size and saturates at MAX_ENTRIES; it should only be written while the
// block is idle. The memory needs no clearing pass after reset, since only
// entries below the count are ever read.
`default_nettype none
`include "bounded_set_span_tracker_defines.svh"

module bounded_set_span_tracker (
  input  wire                            clk,
  input  wire                            rst,
  // Input stream: s_tdata[31:0] = value.
  input  wire                            s_tvalid,
  output logic                           s_tready,
  input  wire  [bsst_pkg::S_TDATA_W-1:0] s_tdata,
  // Result stream: m_tdata[10:0] = count, [42:11] = shortest_span,
  // [74:43] = longest_span, [79:75] = zero.
  output logic                           m_tvalid,
  input  wire                            m_tready,
  output logic [bsst_pkg::M_TDATA_W-1:0] m_tdata,
  // m_tuser[1:0] = status, [2] = spans_valid.
  output logic [bsst_pkg::M_TUSER_W-1:0] m_tuser,
  // Configuration port.
  input  wire                            psel,
  input  wire                            penable,
  input  wire                            pwrite,
  input  wire [bsst_pkg::APB_ADDR_W-1:0] paddr,
  input  wire [bsst_pkg::APB_DATA_W-1:0] pwdata,
  output logic [bsst_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);
  import bsst_pkg::*;

  // Entry store: synchronous read, registered data.
  logic [VALUE_W-1:0] entry_store [MAX_ENTRIES];

  bsst_state_t state, state_next;

  logic [CAP_W-1:0]   capacity;
  logic [COUNT_W-1:0] entry_count;
  logic [VALUE_W-1:0] smallest_entry;
  logic [VALUE_W-1:0] largest_entry;
  logic [VALUE_W-1:0] min_gap;

  // Per-item working registers.
  logic [VALUE_W-1:0] value_q;
  logic               full_q;
  logic               dup;
  logic               has_lo;
  logic               has_hi;
  logic [VALUE_W-1:0] lo;
  logic [VALUE_W-1:0] hi;

  // Scan read pipeline.
  logic [COUNT_W-1:0] rd_idx;
  logic               rd_pend;
  logic [VALUE_W-1:0] rd_data;

  logic in_fire;
  logic out_free;
  logic mem_re;
  logic mem_we;
  logic finish;
  logic is_new;
  logic full_now;
  logic cfg_write;

  logic [VALUE_W-1:0] vk, ek, lok, hik;
  logic [VALUE_W-1:0] g_lo, g_hi, gap_a;
  logic [VALUE_W-1:0] min_gap_next;
  logic [VALUE_W-1:0] smallest_next;
  logic [VALUE_W-1:0] largest_next;
  logic [VALUE_W-1:0] longest_span;
  logic [COUNT_W-1:0] entry_count_next;
  logic               spans_valid;
  bsst_status_t       status;

  // --------------------------------------------------------------------------
  // Configuration port. Only one register; paddr[2] selects the word.
  // --------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_CAPACITY);

  always_comb begin
    if (paddr[2] == REG_CAPACITY) begin
      prdata = APB_DATA_W'(capacity);
    end else begin
      prdata = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_write) begin
      capacity <= pwdata[CAP_W-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Handshake and controller.
  // --------------------------------------------------------------------------
  assign s_tready = (state == ST_IDLE);
  assign in_fire  = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // The set is full when the count has reached the capacity, which itself
  // saturates at the depth of the store.
  assign full_now = (32'(entry_count) >= 32'(capacity)) ||
                    (32'(entry_count) >= 32'(MAX_ENTRIES));

  // A read is issued for every held entry; the last compare happens the
  // cycle after the last read, when rd_pend is still set.
  assign mem_re = (state == ST_SCAN) && (rd_idx < entry_count);
  assign finish = (state == ST_FINISH) && out_free;
  assign is_new = !full_q && !dup;
  assign mem_we = finish && is_new;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          state_next = full_now ? ST_FINISH : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!mem_re && !rd_pend) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // --------------------------------------------------------------------------
  // Entry store. Writes only happen in the finish step, after all scan reads
  // have returned, so no read can see a write in flight.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (mem_we) begin
      entry_store[entry_count[ADDR_W-1:0]] <= value_q;
    end
    if (mem_re) begin
      rd_data <= entry_store[rd_idx[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= mem_re;
    end
  end

  // --------------------------------------------------------------------------
  // Scan: flipping the sign bit turns the signed order into an unsigned one.
  // --------------------------------------------------------------------------
  assign vk  = value_q ^ SIGN_BIT;
  assign ek  = rd_data ^ SIGN_BIT;
  assign lok = lo ^ SIGN_BIT;
  assign hik = hi ^ SIGN_BIT;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx <= '0;
      dup    <= 1'b0;
      has_lo <= 1'b0;
      has_hi <= 1'b0;
      full_q <= 1'b0;
    end else if (in_fire) begin
      rd_idx <= '0;
      dup    <= 1'b0;
      has_lo <= 1'b0;
      has_hi <= 1'b0;
      full_q <= full_now;
    end else begin
      if (mem_re) begin
        rd_idx <= rd_idx + 1'b1;
      end
      if (rd_pend) begin
        if (ek == vk) begin
          dup <= 1'b1;
        end else if (ek < vk) begin
          if (!has_lo || ek > lok) begin
            has_lo <= 1'b1;
          end
        end else begin
          if (!has_hi || ek < hik) begin
            has_hi <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      value_q <= s_tdata[VALUE_W-1:0];
    end
    if (rd_pend && (ek < vk) && (!has_lo || ek > lok)) begin
      lo <= rd_data;
    end
    if (rd_pend && (ek > vk) && (!has_hi || ek < hik)) begin
      hi <= rd_data;
    end
  end

  // --------------------------------------------------------------------------
  // Finish step: fold the neighbors into the tracked gap and range.
  // Unsigned wrap-around of the differences gives the exact distance.
  // --------------------------------------------------------------------------
  assign g_lo  = value_q - lo;
  assign g_hi  = hi - value_q;
  assign gap_a = (has_lo && (g_lo < min_gap)) ? g_lo : min_gap;

  always_comb begin
    min_gap_next     = min_gap;
    smallest_next    = smallest_entry;
    largest_next     = largest_entry;
    entry_count_next = entry_count;
    if (is_new) begin
      min_gap_next     = (has_hi && (g_hi < gap_a)) ? g_hi : gap_a;
      entry_count_next = entry_count + 1'b1;
      if (entry_count == '0) begin
        smallest_next = value_q;
        largest_next  = value_q;
      end else begin
        if (vk < (smallest_entry ^ SIGN_BIT)) begin
          smallest_next = value_q;
        end
        if (vk > (largest_entry ^ SIGN_BIT)) begin
          largest_next = value_q;
        end
      end
    end
  end

  always_comb begin
    if (full_q) begin
      status = STATUS_FULL;
    end else if (dup) begin
      status = STATUS_DUP;
    end else begin
      status = STATUS_NEW;
    end
  end

  assign spans_valid  = (32'(entry_count_next) >= 32'd2);
  assign longest_span = largest_next - smallest_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count    <= '0;
      smallest_entry <= '0;
      largest_entry  <= '0;
      min_gap        <= '1;
    end else if (finish) begin
      entry_count    <= entry_count_next;
      smallest_entry <= smallest_next;
      largest_entry  <= largest_next;
      min_gap        <= min_gap_next;
    end
  end

  // --------------------------------------------------------------------------
  // Output register. It holds a result until taken while the next item is
  // already accepted and scanned.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (finish) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      m_tdata <= {5'b0,
                  spans_valid ? longest_span : {VALUE_W{1'b0}},
                  spans_valid ? min_gap_next : {VALUE_W{1'b0}},
                  OUT_COUNT_W'(entry_count_next)};
      m_tuser <= {spans_valid, status};
    end
  end

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  `BSST_ASSERT_SAME(a_count_bound, 1'b1, 32'(entry_count) <= 32'(MAX_ENTRIES), "count beyond store depth")
  `BSST_ASSERT_SAME(a_write_in_finish, mem_we, (state == ST_FINISH) && !rd_pend, "store write outside finish step")
  `BSST_ASSERT_SAME(a_read_in_range, mem_re, rd_idx < entry_count, "scan read beyond held entries")
  `BSST_ASSERT_NEXT(a_leave_idle, in_fire, state != ST_IDLE, "accepted item did not start processing")
  `BSST_ASSERT_SAME(a_span_order, m_tvalid && m_tuser[2], m_tdata[42:11] <= m_tdata[74:43], "shortest span exceeds longest span")

endmodule

`default_nettype wire

/* tb/sv/bounded_set_span_tracker_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Span tracker result checker
// Watches the configuration port and both streams. It keeps its own copy of
// the set and predicts one result per accepted value. It compares every
// result with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module bounded_set_span_tracker_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  input  logic [bsst_pkg::S_TDATA_W-1:0]  s_tdata,   // [31:0] value
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  // [10:0] count, [42:11] shortest, [74:43] longest
  input  logic [bsst_pkg::M_TDATA_W-1:0]  m_tdata,
  input  logic [bsst_pkg::M_TUSER_W-1:0]  m_tuser,   // [1:0] status, [2] spans_valid
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [bsst_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [bsst_pkg::APB_DATA_W-1:0] pwdata,
  input  logic                            pready,
  output int                              mismatches,
  output int                              in_flight,
  output int                              set_size
);
  import bsst_pkg::*;

  typedef struct {
    bsst_status_t         status;
    logic [OUT_COUNT_W-1:0] count;
    logic [VALUE_W-1:0]   shortest;
    logic [VALUE_W-1:0]   longest;
    logic                 spans_valid;
  } span_report_t;

  // Shadow copy of the block's state.
  logic [VALUE_W-1:0] held_values[$];
  logic [VALUE_W-1:0] lowest_value;
  logic [VALUE_W-1:0] highest_value;
  logic [VALUE_W-1:0] tightest_gap;
  logic [CAP_W-1:0]   capacity;

  span_report_t reports_due[$];
  int           inserts_seen;
  int           reports_seen;

  initial mismatches = 0;
  assign in_flight = inserts_seen - reports_seen;

  // Offers one value to the shadow set and returns the report it must cause.
  function automatic span_report_t insert_value(logic [VALUE_W-1:0] v);
    span_report_t       r;
    int                 room;
    bit                 dup;
    bit                 has_lo;
    bit                 has_hi;
    logic [VALUE_W-1:0] lo;
    logic [VALUE_W-1:0] hi;
    room = (capacity > MAX_ENTRIES) ? MAX_ENTRIES : int'(capacity);
    dup = 1'b0;
    has_lo = 1'b0;
    has_hi = 1'b0;
    lo = '0;
    hi = '0;
    if (held_values.size() + 1 > room) begin
      // A full set rejects even a value that it already holds.
      r.status = STATUS_FULL;
    end else begin
      foreach (held_values[i]) begin
        if (held_values[i] == v) begin
          dup = 1'b1;
        end else if ($signed(held_values[i]) < $signed(v)) begin
          if (!has_lo || $signed(held_values[i]) > $signed(lo)) begin
            lo = held_values[i];
            has_lo = 1'b1;
          end
        end else begin
          if (!has_hi || $signed(held_values[i]) < $signed(hi)) begin
            hi = held_values[i];
            has_hi = 1'b1;
          end
        end
      end
      if (dup) begin
        r.status = STATUS_DUP;
      end else begin
        r.status = STATUS_NEW;
        if (held_values.size() == 0) begin
          lowest_value = v;
          highest_value = v;
        end else begin
          if ($signed(v) < $signed(lowest_value)) lowest_value = v;
          if ($signed(v) > $signed(highest_value)) highest_value = v;
        end
        if (has_lo && (v - lo) < tightest_gap) tightest_gap = v - lo;
        if (has_hi && (hi - v) < tightest_gap) tightest_gap = hi - v;
        held_values.push_back(v);
      end
    end
    r.count = OUT_COUNT_W'(held_values.size());
    if (held_values.size() >= 2) begin
      r.shortest = tightest_gap;
      r.longest = highest_value - lowest_value;
      r.spans_valid = 1'b1;
    end else begin
      r.shortest = '0;
      r.longest = '0;
      r.spans_valid = 1'b0;
    end
    return r;
  endfunction

  task automatic check_field(string what, logic [VALUE_W-1:0] want, logic [VALUE_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    span_report_t want;
    if (rst) begin
      held_values.delete();
      reports_due.delete();
      lowest_value = '0;
      highest_value = '0;
      tightest_gap = '1;
      capacity = CAP_RESET;
      inserts_seen <= 0;
      reports_seen <= 0;
      set_size <= 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr[2] == REG_CAPACITY) begin
        capacity = pwdata[CAP_W-1:0];
      end
      // Results are handled before inputs so that a stray result can never
      // match a prediction made in the same cycle.
      if (m_tvalid && m_tready) begin
        reports_seen <= reports_seen + 1;
        if (reports_due.size() == 0) begin
          $display("%0t: result with nothing expected, actual tdata 0x%0h tuser 0x%0h",
                   $time, m_tdata, m_tuser);
          mismatches++;
        end else begin
          want = reports_due.pop_front();
          check_field("status", 32'(want.status), 32'(m_tuser[1:0]));
          check_field("spans_valid", 32'(want.spans_valid), 32'(m_tuser[2]));
          check_field("count", 32'(want.count), 32'(m_tdata[10:0]));
          check_field("shortest_span", want.shortest, m_tdata[42:11]);
          check_field("longest_span", want.longest, m_tdata[74:43]);
        end
      end
      if (s_tvalid && s_tready) begin
        reports_due.push_back(insert_value(s_tdata[VALUE_W-1:0]));
        inserts_seen <= inserts_seen + 1;
      end
      set_size <= held_values.size();
    end
  end

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Span tracker testbench
// Drives values and capacity settings into the span tracker and leaves all
// prediction and comparison to the checker that sits beside it.
// ----------------------------------------------------------------------------
module testbench;
  import bsst_pkg::*;

  // The set only ever grows, and every insert scans all held entries. The run
  // sends about 580 transactions, so the count never passes 600, and the
  // limit leaves ample room for the slowest correct run, stalls included.
  localparam int unsigned LIMIT_CYCLES = 2_000_000;
  localparam logic [APB_ADDR_W-1:0] CAPACITY_ADDR = {REG_CAPACITY, 2'b00};
  localparam int IDLE_PERCENT = 27;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [S_TDATA_W-1:0]  s_tdata = '0;   // [31:0] value
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_tdata;        // [10:0] count, [42:11] shortest, [74:43] longest
  logic [M_TUSER_W-1:0]  m_tuser;        // [1:0] status, [2] spans_valid
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  int mismatches;
  int in_flight;
  int set_size;

  // When cleared, the matching side of the stream runs without any gaps.
  bit src_gaps = 1'b1;
  bit sink_stalls = 1'b1;

  int unsigned cycle_count = 0;

  always #5 clk = ~clk;

  bounded_set_span_tracker dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  bounded_set_span_tracker_checker span_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .pready     (pready),
    .mismatches (mismatches),
    .in_flight  (in_flight),
    .set_size   (set_size)
  );

  // The result side stalls on a random share of the cycles while stalls are
  // enabled. Stalls only hold the block in its finish step, since the scan
  // itself does not wait on m_tready.
  always @(posedge clk) begin
    m_tready <= !sink_stalls || ($urandom_range(0, 99) >= IDLE_PERCENT);
  end

  // Watchdog: a hung handshake must not keep the run alive forever.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Two-phase register write: a setup cycle, then the access cycle that
  // commits the data once pready is seen.
  task automatic write_capacity(int unsigned cap);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CAPACITY_ADDR;
    pwdata <= APB_DATA_W'(cap);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Offers one value and returns at the edge where it is taken. tvalid stays
  // high afterwards, so back-to-back transactions need no gap in tvalid.
  task automatic send_value(logic [VALUE_W-1:0] v);
    while (src_gaps && $urandom_range(0, 99) < IDLE_PERCENT) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= v;
    do @(posedge clk); while (!s_tready);
  endtask

  // Drops tvalid and waits until every accepted value has its result. Every
  // value causes a result, so a short margin is enough before a write.
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (in_flight != 0);
    repeat (4) @(posedge clk);
  endtask

  // Random values lean toward three dense clusters, near zero and near both
  // ends of the range, so duplicates, gaps of one and wrapping differences
  // show up often. The rest are uniform over all 32 bits.
  function automatic logic [VALUE_W-1:0] pick_value();
    logic [VALUE_W-1:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = VALUE_W'($urandom_range(0, 400)) - 32'd200;
      4:          v = 32'h7FFF_FFFF - VALUE_W'($urandom_range(0, 40));
      5:          v = 32'h8000_0000 + VALUE_W'($urandom_range(0, 40));
      default:    v = $urandom();
    endcase
    return v;
  endfunction

  task automatic random_burst(int n);
    repeat (n) send_value(pick_value());
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Zero capacity: everything is turned away and the set stays empty.
    write_capacity(0);
    send_value(32'h8000_0000);
    send_value(32'h7FFF_FFFF);
    send_value(32'h0000_0000);
    drain();

    // Room for one entry: the second offer of the same value is rejected as
    // full rather than reported as a duplicate.
    write_capacity(1);
    send_value(32'h7FFF_FFFF);
    send_value(32'h7FFF_FFFF);
    send_value(32'hFFFF_FFFF);
    drain();

    // Room for three: duplicates are now ignored, and the two extremes give
    // a gap and a range that only fit as unsigned numbers.
    write_capacity(3);
    send_value(32'h7FFF_FFFF);
    send_value(32'h8000_0000);
    send_value(32'h8000_0000);
    send_value(32'h0000_0000);
    send_value(32'h0000_0001);
    send_value(32'h0000_0000);
    drain();

    // Capacity above the memory size saturates. Neighbors one apart at both
    // ends and around zero drive the smallest gap down to one.
    write_capacity(2047);
    send_value(32'hFFFF_FFFF);
    send_value(32'h0000_0000);
    send_value(32'h0000_0005);
    send_value(32'h7FFF_FFFE);
    send_value(32'h8000_0001);
    send_value(32'h8000_0001);
    drain();

    // A small headroom fills the set quickly, after which most transactions
    // are rejections.
    write_capacity(set_size + 20);
    random_burst(120);
    drain();

    // Full capacity with both sides running flat out.
    src_gaps = 1'b0;
    sink_stalls = 1'b0;
    write_capacity(MAX_ENTRIES);
    random_burst(120);
    drain();
    src_gaps = 1'b1;
    sink_stalls = 1'b1;

    // Capacity at or below the current count: every value is rejected.
    write_capacity($urandom_range(0, set_size));
    random_burst(100);
    drain();

    write_capacity(MAX_ENTRIES);
    random_burst(120);
    drain();

    // Grow the set further under the saturated capacity, then offer the two
    // extremes, which are held by now and must come back as duplicates.
    write_capacity(2047);
    random_burst(90);
    send_value(32'h7FFF_FFFF);
    send_value(32'h8000_0000);
    random_burst(8);
    drain();

    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
